>>> design/wirp_pkg.sv
package wirp_pkg;

	typedef enum logic [1:0] {
		PH_WORD = 2'd0,
		PH_TAIL = 2'd1,
		PH_HALT = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_LONG_WORD  = 2'd0;
	localparam logic [1:0] ERR_EMPTY_WORD = 2'd1;
	localparam logic [1:0] ERR_END_TAIL   = 2'd2;
	localparam logic [1:0] ERR_NO_RECORDS = 2'd3;

	localparam logic [2:0] TAIL_LAST = 3'd7;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  char_value;
		logic [4:0]  char_index;
		logic [31:0] word_start;
		logic [31:0] dict_offset;
		logic [31:0] dict_size;
		logic [4:0]  kept_length;
		logic [7:0]  full_length;
		logic [31:0] record_total;
		logic [31:0] file_length;
		logic [1:0]  error_code;
	} result_t;

endpackage

>>> design/wirp_core.sv
module wirp_core #(
	parameter int KEY_BYTES    = 32,
	parameter int MAX_WORD_LEN = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               end_of_file,
	output logic               emit,
	output wirp_pkg::result_t  result
);

	localparam int KEEP = (KEY_BYTES - 1 > 31) ? 31 : KEY_BYTES - 1;
	localparam logic [7:0] KEEP_W = 8'(KEEP);
	localparam logic [8:0] MAX_W  = 9'(MAX_WORD_LEN);

	wirp_pkg::phase_t phase_q, phase_n;
	logic [31:0] byte_pos_q, byte_pos_n;
	logic [31:0] word_start_q, word_start_n;
	logic [7:0]  word_len_q, word_len_n;
	logic [2:0]  tail_cnt_q, tail_cnt_n;
	logic [55:0] tail_shift_q, tail_shift_n;
	logic [31:0] rec_cnt_q, rec_cnt_n;

	always_comb begin
		phase_n      = phase_q;
		byte_pos_n   = byte_pos_q;
		word_start_n = word_start_q;
		word_len_n   = word_len_q;
		tail_cnt_n   = tail_cnt_q;
		tail_shift_n = tail_shift_q;
		rec_cnt_n    = rec_cnt_q;
		emit         = 1'b0;
		result       = '0;
		if (phase_q == wirp_pkg::PH_WORD || phase_q == wirp_pkg::PH_TAIL) begin
			if (end_of_file) begin
				emit    = 1'b1;
				phase_n = wirp_pkg::PH_HALT;
				if (phase_q == wirp_pkg::PH_TAIL) begin
					result.result_kind = wirp_pkg::KIND_ERROR;
					result.error_code  = wirp_pkg::ERR_END_TAIL;
				end else if (rec_cnt_q == '0) begin
					result.result_kind = wirp_pkg::KIND_ERROR;
					result.error_code  = wirp_pkg::ERR_NO_RECORDS;
				end else begin
					result.result_kind  = wirp_pkg::KIND_DONE;
					result.record_total = rec_cnt_q;
					result.file_length  = byte_pos_q;
				end
			end else begin
				byte_pos_n = byte_pos_q + 32'd1;
				if (phase_q == wirp_pkg::PH_WORD) begin
					if (word_len_q == '0)
						word_start_n = byte_pos_q;
					if (data_byte == '0) begin
						if (word_len_q == '0) begin
							emit               = 1'b1;
							phase_n            = wirp_pkg::PH_HALT;
							result.result_kind = wirp_pkg::KIND_ERROR;
							result.error_code  = wirp_pkg::ERR_EMPTY_WORD;
						end else begin
							phase_n      = wirp_pkg::PH_TAIL;
							tail_cnt_n   = '0;
							tail_shift_n = '0;
						end
					end else if ({1'b0, word_len_q} + 9'd1 > MAX_W) begin
						emit               = 1'b1;
						phase_n            = wirp_pkg::PH_HALT;
						result.result_kind = wirp_pkg::KIND_ERROR;
						result.error_code  = wirp_pkg::ERR_LONG_WORD;
					end else begin
						word_len_n = word_len_q + 8'd1;
						if (word_len_q < KEEP_W) begin
							emit               = 1'b1;
							result.result_kind = wirp_pkg::KIND_CHAR;
							result.char_value  = data_byte;
							result.char_index  = word_len_q[4:0];
						end
					end
				end else if (tail_cnt_q != wirp_pkg::TAIL_LAST) begin
					tail_shift_n = {tail_shift_q[47:0], data_byte};
					tail_cnt_n   = tail_cnt_q + 3'd1;
				end else begin
					emit               = 1'b1;
					result.result_kind = wirp_pkg::KIND_RECORD;
					result.word_start  = word_start_q;
					result.dict_offset = tail_shift_q[55:24];
					result.dict_size   = {tail_shift_q[23:0], data_byte};
					result.kept_length = (word_len_q < KEEP_W) ? word_len_q[4:0] : KEEP_W[4:0];
					result.full_length = word_len_q;
					if (rec_cnt_q != '1)
						rec_cnt_n = rec_cnt_q + 32'd1;
					phase_n      = wirp_pkg::PH_WORD;
					word_len_n   = '0;
					tail_cnt_n   = '0;
					tail_shift_n = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= wirp_pkg::PH_WORD;
			byte_pos_q   <= '0;
			word_start_q <= '0;
			word_len_q   <= '0;
			tail_cnt_q   <= '0;
			tail_shift_q <= '0;
			rec_cnt_q    <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			byte_pos_q   <= byte_pos_n;
			word_start_q <= word_start_n;
			word_len_q   <= word_len_n;
			tail_cnt_q   <= tail_cnt_n;
			tail_shift_q <= tail_shift_n;
			rec_cnt_q    <= rec_cnt_n;
		end
	end

endmodule

>>> design/wirp_out_reg.sv
module wirp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wirp_pkg::result_t  push_data,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output wirp_pkg::result_t  out_data
);

	logic              valid_q;
	wirp_pkg::result_t data_q;

	// loads when empty or when the held request leaves this cycle
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			data_q <= push_data;
	end

endmodule

>>> design/word_index_record_parser_unit.sv
// Path: an accepted byte is held in the input register, and its result is then written
// to the result register, which drives the output (input register, then result register).
// Throughput: one byte per cycle while the output is not stalled; the parse state update is one short step per byte.
// Reset: arst_n clears the parse state, byte position and record count and
// empties both registers; after a done or error result the unit ignores input until reset.
module word_index_record_parser_unit #(
	parameter int KEY_BYTES    = 32,
	parameter int MAX_WORD_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  char_value,
	output logic [4:0]  char_index,
	output logic [31:0] word_start,
	output logic [31:0] dict_offset,
	output logic [31:0] dict_size,
	output logic [4:0]  kept_length,
	output logic [7:0]  full_length,
	output logic [31:0] record_total,
	output logic [31:0] file_length,
	output logic [1:0]  error_code
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              eof_s1;
	logic              can_load;
	logic              advance;
	logic              emit;
	wirp_pkg::result_t core_res;
	wirp_pkg::result_t out_res;

	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	wirp_core #(
		.KEY_BYTES    (KEY_BYTES),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (data_s1),
		.end_of_file (eof_s1),
		.emit        (emit),
		.result      (core_res)
	);

	wirp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && emit),
		.push_data (core_res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign result_kind  = out_res.result_kind;
	assign char_value   = out_res.char_value;
	assign char_index   = out_res.char_index;
	assign word_start   = out_res.word_start;
	assign dict_offset  = out_res.dict_offset;
	assign dict_size    = out_res.dict_size;
	assign kept_length  = out_res.kept_length;
	assign full_length  = out_res.full_length;
	assign record_total = out_res.record_total;
	assign file_length  = out_res.file_length;
	assign error_code   = out_res.error_code;

endmodule

>>> design/wirp_checker.sv
module wirp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [4:0]  char_index,
	input logic [4:0]  kept_length,
	input logic [7:0]  full_length
);

	// stalled request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind))
		else $error("output request changed while stalled");

	// done or error is final
	a_halt_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready &&
		(result_kind == wirp_pkg::KIND_DONE || result_kind == wirp_pkg::KIND_ERROR)
		|=> !out_valid)
		else $error("request after done or error");

	a_char_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == wirp_pkg::KIND_CHAR |-> char_index != 5'd31)
		else $error("character index out of range");

	a_record_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == wirp_pkg::KIND_RECORD
		|-> full_length != 8'd0 && {3'd0, kept_length} <= full_length)
		else $error("record lengths inconsistent");

endmodule

bind word_index_record_parser_unit wirp_checker u_wirp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.char_index  (char_index),
	.kept_length (kept_length),
	.full_length (full_length)
);

>>> test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_BYTES    = 32;
	localparam int MAX_WORD_LEN = 255;
	localparam int KEEP         = (KEY_BYTES - 1 > 31) ? 31 : KEY_BYTES - 1;
	localparam int TARGET_BYTES = 1300;
	localparam int CYCLE_LIMIT  = 200000;

	// Running model of the parser plus the queue of results it still owes.
	class record_scoreboard;
		wirp_pkg::phase_t  phase;
		logic [31:0]       position;
		logic [31:0]       word_begin;
		int unsigned       word_len;
		logic [2:0]        tail_count;
		logic [55:0]       tail_bytes;
		logic [31:0]       records;
		wirp_pkg::result_t owed[$];
		int                faults;

		function new();
			phase      = wirp_pkg::PH_WORD;
			position   = '0;
			word_begin = '0;
			word_len   = 0;
			tail_count = '0;
			tail_bytes = '0;
			records    = '0;
			faults     = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void halt_with(logic [1:0] code);
			wirp_pkg::result_t r;
			r = '0;
			r.result_kind = wirp_pkg::KIND_ERROR;
			r.error_code  = code;
			phase = wirp_pkg::PH_HALT;
			owed.push_back(r);
		endfunction

		// Advance the model by one accepted request.
		function void note_request(logic [7:0] b, logic eof);
			wirp_pkg::result_t r;
			logic [31:0]       pos;
			r = '0;
			if (phase != wirp_pkg::PH_WORD && phase != wirp_pkg::PH_TAIL)
				return;
			if (eof) begin
				if (phase == wirp_pkg::PH_TAIL)
					halt_with(wirp_pkg::ERR_END_TAIL);
				else if (records == '0)
					halt_with(wirp_pkg::ERR_NO_RECORDS);
				else begin
					phase = wirp_pkg::PH_HALT;
					r.result_kind  = wirp_pkg::KIND_DONE;
					r.record_total = records;
					r.file_length  = position;
					owed.push_back(r);
				end
				return;
			end
			pos      = position;
			position = position + 32'd1;
			if (phase == wirp_pkg::PH_WORD) begin
				if (word_len == 0)
					word_begin = pos;
				if (b == 8'h00) begin
					if (word_len == 0)
						halt_with(wirp_pkg::ERR_EMPTY_WORD);
					else begin
						phase      = wirp_pkg::PH_TAIL;
						tail_count = '0;
						tail_bytes = '0;
					end
					return;
				end
				if (word_len >= MAX_WORD_LEN) begin
					halt_with(wirp_pkg::ERR_LONG_WORD);
					return;
				end
				if (word_len < KEEP) begin
					r.result_kind = wirp_pkg::KIND_CHAR;
					r.char_value  = b;
					r.char_index  = 5'(word_len);
					owed.push_back(r);
				end
				word_len++;
				return;
			end
			// tail: seven bytes shift in, the eighth completes the record
			if (tail_count != wirp_pkg::TAIL_LAST) begin
				tail_bytes = {tail_bytes[47:0], b};
				tail_count = tail_count + 3'd1;
				return;
			end
			r.result_kind = wirp_pkg::KIND_RECORD;
			r.word_start  = word_begin;
			r.dict_offset = tail_bytes[55:24];
			r.dict_size   = {tail_bytes[23:0], b};
			r.kept_length = 5'((word_len < KEEP) ? word_len : KEEP);
			r.full_length = 8'(word_len);
			if (records != '1)
				records = records + 32'd1;
			phase      = wirp_pkg::PH_WORD;
			word_len   = 0;
			tail_count = '0;
			tail_bytes = '0;
			owed.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				faults++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(wirp_pkg::result_t got);
			wirp_pkg::result_t want;
			if (owed.size() == 0) begin
				faults++;
				$display("%0t: unexpected result kind %0d, expected none, actual %p",
					$time, got.result_kind, got);
				return;
			end
			want = owed.pop_front();
			check_field("result_kind", want.result_kind, got.result_kind);
			check_field("char_value", want.char_value, got.char_value);
			check_field("char_index", want.char_index, got.char_index);
			check_field("word_start", want.word_start, got.word_start);
			check_field("dict_offset", want.dict_offset, got.dict_offset);
			check_field("dict_size", want.dict_size, got.dict_size);
			check_field("kept_length", want.kept_length, got.kept_length);
			check_field("full_length", want.full_length, got.full_length);
			check_field("record_total", want.record_total, got.record_total);
			check_field("file_length", want.file_length, got.file_length);
			check_field("error_code", want.error_code, got.error_code);
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [7:0]  data_byte   = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  result_kind;
	logic [7:0]  char_value;
	logic [4:0]  char_index;
	logic [31:0] word_start;
	logic [31:0] dict_offset;
	logic [31:0] dict_size;
	logic [4:0]  kept_length;
	logic [7:0]  full_length;
	logic [31:0] record_total;
	logic [31:0] file_length;
	logic [1:0]  error_code;

	record_scoreboard sb = new();
	bit steady = 1'b0;
	int sent = 0;
	int cycles = 0;

	word_index_record_parser_unit #(
		.KEY_BYTES(KEY_BYTES),
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.char_value(char_value),
		.char_index(char_index),
		.word_start(word_start),
		.dict_offset(dict_offset),
		.dict_size(dict_size),
		.kept_length(kept_length),
		.full_length(full_length),
		.record_total(record_total),
		.file_length(file_length),
		.error_code(error_code)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("word_index_record_parser_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin : drain
		wirp_pkg::result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.result_kind  = result_kind;
			seen.char_value   = char_value;
			seen.char_index   = char_index;
			seen.word_start   = word_start;
			seen.dict_offset  = dict_offset;
			seen.dict_size    = dict_size;
			seen.kept_length  = kept_length;
			seen.full_length  = full_length;
			seen.record_total = record_total;
			seen.file_length  = file_length;
			seen.error_code   = error_code;
			sb.check_result(seen);
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(0, 99) >= 38);
	end

	task automatic send_item(input logic [7:0] b, input logic e);
		if (!steady && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_file <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(b, e);
		sent++;
	endtask

	// style 0: random nonzero, 1: all 0xFF, 2: all 0x01
	task automatic send_word(input int len, input int style);
		for (int i = 0; i < len; i++) begin
			case (style)
				1: send_item(8'hFF, 1'b0);
				2: send_item(8'h01, 1'b0);
				default: send_item(8'($urandom_range(1, 255)), 1'b0);
			endcase
		end
	endtask

	task automatic send_tail(input logic [63:0] tail, input int count);
		for (int i = 0; i < count; i++)
			send_item(tail[63 - 8 * i -: 8], 1'b0);
	endtask

	task automatic send_record(input int len, input int style, input logic [63:0] tail);
		send_word(len, style);
		send_item(8'h00, 1'b0);
		send_tail(tail, 8);
	endtask

	function automatic logic [63:0] pick_tail();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 12);
		if (r < 90)
			return $urandom_range(13, 40);
		return $urandom_range(41, MAX_WORD_LEN);
	endfunction

	initial begin
		int ending;
		int n;
		ending = $urandom_range(0, 5);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		if (ending == 0) begin
			// file with no complete record: only a partial word, maybe none
			send_word($urandom_range(0, 40), 0);
			send_item(8'($urandom), 1'b1);
		end else begin
			send_record(1, 1, '1);
			send_record(1, 2, '0);
			send_record(KEEP, 0, pick_tail());
			send_record(KEEP + 1, 0, 64'h0123_4567_89AB_CDEF);

			n = 0;
			while (sent < TARGET_BYTES) begin
				steady = (n >= 20 && n < 45);
				if (n == 10) begin
					in_valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
				send_record((n == 3) ? MAX_WORD_LEN : pick_length(), 0, pick_tail());
				n++;
			end
			steady = 1'b0;

			case (ending)
				1: send_item(8'($urandom), 1'b1);
				2: begin
					send_word($urandom_range(1, 40), 0);
					send_item(8'($urandom), 1'b1);
				end
				3: begin
					// word one byte past the maximum
					send_word(MAX_WORD_LEN + 1, 0);
				end
				4: send_item(8'h00, 1'b0);
				default: begin
					send_word($urandom_range(1, 20), 0);
					send_item(8'h00, 1'b0);
					send_tail(pick_tail(), $urandom_range(0, 7));
					send_item(8'($urandom), 1'b1);
				end
			endcase
		end

		// halted: everything from here on must be ignored
		repeat (6) send_item(8'($urandom), 1'($urandom));
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("word_index_record_parser_unit: match");
		else
			$display("word_index_record_parser_unit: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/wirp_pkg.sv
design/wirp_core.sv
design/wirp_out_reg.sv
design/word_index_record_parser_unit.sv
design/wirp_checker.sv
test/tb.sv
